// File: hdl/hpack_huffman_encoder_core_assert.svh
// Assertion macros for the HPACK Huffman encoder.
`ifndef HPACK_HUFFMAN_ENCODER_CORE_ASSERT_SVH
`define HPACK_HUFFMAN_ENCODER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HPE_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("hpe assertion failed");
`define HPE_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("hpe assertion failed");
`else
`define HPE_ASSERT_IMP(label, clk, rst_n, a, b)
`define HPE_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

// File: hdl/hpe_pkg.sv
// Shared types, constants and the static Huffman code ROM.
package hpe_pkg;

    localparam int CODE_W      = 30;   // longest code
    localparam int LEN_W       = 5;
    localparam int WORD_W      = 40;   // 7 pending + 30 code bits, rounded to bytes
    localparam int CNT_W       = 3;    // bytes per request, 0..5
    localparam int PEND_W      = 7;
    localparam int QUEUE_DEPTH = 4;

    // One request's worth of output bytes, left-aligned in word.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [CNT_W-1:0]  count;
        logic              last;
    } pkt_t;

    // Codes, right-aligned.
    localparam logic [CODE_W-1:0] HC_CODE [256] = '{
        'h1ff8,'h7fffd8,'hfffffe2,'hfffffe3,'hfffffe4,'hfffffe5,'hfffffe6,'hfffffe7,
        'hfffffe8,'hffffea,'h3ffffffc,'hfffffe9,'hfffffea,'h3ffffffd,'hfffffeb,'hfffffec,
        'hfffffed,'hfffffee,'hfffffef,'hffffff0,'hffffff1,'hffffff2,'h3ffffffe,'hffffff3,
        'hffffff4,'hffffff5,'hffffff6,'hffffff7,'hffffff8,'hffffff9,'hffffffa,'hffffffb,
        'h14,'h3f8,'h3f9,'hffa,'h1ff9,'h15,'hf8,'h7fa,
        'h3fa,'h3fb,'hf9,'h7fb,'hfa,'h16,'h17,'h18,
        'h0,'h1,'h2,'h19,'h1a,'h1b,'h1c,'h1d,
        'h1e,'h1f,'h5c,'hfb,'h7ffc,'h20,'hffb,'h3fc,
        'h1ffa,'h21,'h5d,'h5e,'h5f,'h60,'h61,'h62,
        'h63,'h64,'h65,'h66,'h67,'h68,'h69,'h6a,
        'h6b,'h6c,'h6d,'h6e,'h6f,'h70,'h71,'h72,
        'hfc,'h73,'hfd,'h1ffb,'h7fff0,'h1ffc,'h3ffc,'h22,
        'h7ffd,'h3,'h23,'h4,'h24,'h5,'h25,'h26,
        'h27,'h6,'h74,'h75,'h28,'h29,'h2a,'h7,
        'h2b,'h76,'h2c,'h8,'h9,'h2d,'h77,'h78,
        'h79,'h7a,'h7b,'h7ffe,'h7fc,'h3ffd,'h1ffd,'hffffffc,
        'hfffe6,'h3fffd2,'hfffe7,'hfffe8,'h3fffd3,'h3fffd4,'h3fffd5,'h7fffd9,
        'h3fffd6,'h7fffda,'h7fffdb,'h7fffdc,'h7fffdd,'h7fffde,'hffffeb,'h7fffdf,
        'hffffec,'hffffed,'h3fffd7,'h7fffe0,'hffffee,'h7fffe1,'h7fffe2,'h7fffe3,
        'h7fffe4,'h1fffdc,'h3fffd8,'h7fffe5,'h3fffd9,'h7fffe6,'h7fffe7,'hffffef,
        'h3fffda,'h1fffdd,'hfffe9,'h3fffdb,'h3fffdc,'h7fffe8,'h7fffe9,'h1fffde,
        'h7fffea,'h3fffdd,'h3fffde,'hfffff0,'h1fffdf,'h3fffdf,'h7fffeb,'h7fffec,
        'h1fffe0,'h1fffe1,'h3fffe0,'h1fffe2,'h7fffed,'h3fffe1,'h7fffee,'h7fffef,
        'hfffea,'h3fffe2,'h3fffe3,'h3fffe4,'h7ffff0,'h3fffe5,'h3fffe6,'h7ffff1,
        'h3ffffe0,'h3ffffe1,'hfffeb,'h7fff1,'h3fffe7,'h7ffff2,'h3fffe8,'h1ffffec,
        'h3ffffe2,'h3ffffe3,'h3ffffe4,'h7ffffde,'h7ffffdf,'h3ffffe5,'hfffff1,'h1ffffed,
        'h7fff2,'h1fffe3,'h3ffffe6,'h7ffffe0,'h7ffffe1,'h3ffffe7,'h7ffffe2,'hfffff2,
        'h1fffe4,'h1fffe5,'h3ffffe8,'h3ffffe9,'hffffffd,'h7ffffe3,'h7ffffe4,'h7ffffe5,
        'hfffec,'hfffff3,'hfffed,'h1fffe6,'h3fffe9,'h1fffe7,'h1fffe8,'h7ffff3,
        'h3fffea,'h3fffeb,'h1ffffee,'h1ffffef,'hfffff4,'hfffff5,'h3ffffea,'h7ffff4,
        'h3ffffeb,'h7ffffe6,'h3ffffec,'h3ffffed,'h7ffffe7,'h7ffffe8,'h7ffffe9,'h7ffffea,
        'h7ffffeb,'hffffffe,'h7ffffec,'h7ffffed,'h7ffffee,'h7ffffef,'h7fffff0,'h3ffffee
    };

    localparam logic [LEN_W-1:0] HC_LEN [256] = '{
        13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
        28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
        6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
        5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
        13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
        7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
        15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
        6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
        20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
        24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
        22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
        21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
        26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
        19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
        20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
        26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26
    };

endpackage

// File: hdl/hpe_front.sv
// Front end: code lookup, bit packing against pending bits, request building.
module hpe_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         sym,
    input  logic               end_of_string,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               q_full,
    output logic               q_push,
    output hpe_pkg::pkt_t      q_pkt,
    output logic [2:0]         pend_cnt
);

    logic                                  a_valid_reg, a_valid_next;
    logic [hpe_pkg::CODE_W-1:0]            a_code_reg;
    logic [hpe_pkg::LEN_W-1:0]             a_len_reg;
    logic                                  a_eos_reg;
    logic [hpe_pkg::PEND_W-1:0]            pend_reg, pend_next;  // left-aligned
    logic [2:0]                            pend_cnt_reg, pend_cnt_next;

    logic                                  a_go;
    logic                                  accept;
    logic [hpe_pkg::LEN_W-1:0]             lk_len;
    logic [hpe_pkg::CODE_W-1:0]            lk_code;
    logic [5:0]                            n;
    logic [2:0]                            nb;
    logic [hpe_pkg::WORD_W-1:0]            word;
    logic [hpe_pkg::WORD_W-1:0]            pad;
    logic [hpe_pkg::WORD_W-1:0]            rest;
    logic                                  part;

    // lookup stage, code left-aligned in 30 bits
    assign lk_len  = hpe_pkg::HC_LEN[sym];
    assign lk_code = hpe_pkg::HC_CODE[sym] << (5'(hpe_pkg::CODE_W) - lk_len);

    assign a_go     = !q_full;
    assign in_stall = a_valid_reg && !a_go;
    assign accept   = in_valid && !in_stall;

    // pack stage
    always_comb
    begin
        n    = 6'(pend_cnt_reg) + 6'(a_len_reg);
        nb   = n[5:3];
        part = (n[2:0] != 3'd0);
        word = {pend_reg, 33'd0} | ({a_code_reg, 10'd0} >> pend_cnt_reg);
        pad  = {hpe_pkg::WORD_W{1'b1}} >> n;
        rest = word << {nb, 3'b000};

        q_pkt.word  = a_eos_reg ? (word | pad) : word;
        q_pkt.count = nb + {2'b00, a_eos_reg && part};
        q_pkt.last  = a_eos_reg;

        pend_next     = pend_reg;
        pend_cnt_next = pend_cnt_reg;
        if (a_valid_reg && a_go)
        begin
            if (a_eos_reg)
            begin
                pend_next     = '0;
                pend_cnt_next = '0;
            end
            else
            begin
                pend_next     = rest[hpe_pkg::WORD_W-1 -: hpe_pkg::PEND_W];
                pend_cnt_next = n[2:0];
            end
        end

        a_valid_next = a_valid_reg;
        if (accept)
            a_valid_next = 1'b1;
        else if (a_go)
            a_valid_next = 1'b0;
    end

    assign q_push   = a_valid_reg && a_go && (q_pkt.count != '0);
    assign pend_cnt = pend_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            pend_reg     <= '0;
            pend_cnt_reg <= '0;
        end
        else
        begin
            a_valid_reg  <= a_valid_next;
            pend_reg     <= pend_next;
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_code_reg <= lk_code;
            a_len_reg  <= lk_len;
            a_eos_reg  <= end_of_string;
        end
    end

endmodule

// File: hdl/hpe_queue.sv
// Small request queue between front and back.
module hpe_queue
#(
    parameter int DEPTH = hpe_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hpe_pkg::pkt_t  push_pkt,
    input  logic           pop,
    output hpe_pkg::pkt_t  head_pkt,
    output logic           full,
    output logic           empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hpe_pkg::pkt_t   entries [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   fill_reg, fill_next;

    assign full     = (fill_reg == CW'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign head_pkt = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_pkt;
    end

endmodule

// File: hdl/hpe_back.sv
// Back end: drains queued requests one byte per cycle into the output register, unless stalled.
module hpe_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  hpe_pkg::pkt_t  head_pkt,
    input  logic           q_empty,
    output logic           q_pop,
    output logic [7:0]     out_byte,
    output logic           last_byte,
    output logic           out_valid,
    input  logic           out_stall
);

    logic [hpe_pkg::WORD_W-1:0]  cur_word_reg, cur_word_next;
    logic [hpe_pkg::CNT_W-1:0]   cur_cnt_reg, cur_cnt_next;
    logic                        cur_last_reg, cur_last_next;
    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  out_byte_reg, out_byte_next;
    logic                        last_byte_reg, last_byte_next;

    logic                        use_cur;
    logic [hpe_pkg::WORD_W-1:0]  src_word;
    logic [hpe_pkg::CNT_W-1:0]   src_cnt;
    logic                        src_last;
    logic                        out_free;
    logic                        emit;

    always_comb
    begin
        use_cur  = (cur_cnt_reg != '0);
        src_word = use_cur ? cur_word_reg : head_pkt.word;
        src_cnt  = use_cur ? cur_cnt_reg  : head_pkt.count;
        src_last = use_cur ? cur_last_reg : head_pkt.last;
        out_free = !out_valid_reg || !out_stall;
        emit     = out_free && (use_cur || !q_empty);
        q_pop    = emit && !use_cur;

        cur_word_next  = cur_word_reg;
        cur_cnt_next   = cur_cnt_reg;
        cur_last_next  = cur_last_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_byte_next = last_byte_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = src_word[hpe_pkg::WORD_W-1 -: 8];
            last_byte_next = src_last && (src_cnt == hpe_pkg::CNT_W'(1));
            cur_word_next  = src_word << 8;
            cur_cnt_next   = src_cnt - 1'b1;
            cur_last_next  = src_last;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_cnt_reg   <= cur_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_word_reg  <= cur_word_next;
        cur_last_reg  <= cur_last_next;
        out_byte_reg  <= out_byte_next;
        last_byte_reg <= last_byte_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_byte_reg;

endmodule

// File: hdl/hpack_huffman_encoder_core.sv
// HPACK static Huffman encoder top level: front packer, request queue, byte drain.
// Path: an accepted octet is registered in the front, queued, then drained into the output register.
// Throughput: one octet per cycle while each octet completes at most one byte; the output
//   port moves one byte per cycle unless stalled; a request holds the back end till its last byte.
// Reset (rst_n low, async): pending bits, queue and output valid cleared; no string open.
`include "hpack_huffman_encoder_core_assert.svh"

module hpack_huffman_encoder_core
#(
    parameter int QUEUE_DEPTH = hpe_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  sym,
    input  logic        end_of_string,
    input  logic        in_valid,
    output logic        in_stall,
    output logic [7:0]  out_byte,
    output logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall
);

    // front -> queue
    logic           q_push;
    hpe_pkg::pkt_t  q_pkt;
    logic           q_full;
    logic [2:0]     pend_cnt;

    // queue -> back
    logic           q_pop;
    logic           q_empty;
    hpe_pkg::pkt_t  head_pkt;

    // Front: one stage of code ROM lookup, then packing against the pending bits.
    // It stalls only when the queue is full.
    hpe_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .sym           (sym),
        .end_of_string (end_of_string),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_pkt         (q_pkt),
        .pend_cnt      (pend_cnt)
    );

    // Each entry is one request's bytes (1..5), left-aligned.
    hpe_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_pkt (q_pkt),
        .pop      (q_pop),
        .head_pkt (head_pkt),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Back: shifts out one byte per cycle into the output register unless out_stall holds it.
    hpe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_pkt  (head_pkt),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_byte  (out_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

    // Queue never overflows or underflows.
    `HPE_ASSERT_IMP(a_no_push_full, clk, rst_n, q_push, !q_full)
    `HPE_ASSERT_IMP(a_no_pop_empty, clk, rst_n, q_pop, !q_empty)
    // Closing a string leaves nothing pending.
    `HPE_ASSERT_NXT(a_eos_clears, clk, rst_n, q_push && q_pkt.last, pend_cnt == 3'd0)
    // A pushed request always carries at least one byte.
    `HPE_ASSERT_IMP(a_push_nonzero, clk, rst_n, q_push, q_pkt.count != 3'd0)

endmodule
